// ----- src/esr_pkg.sv -----
// Package for the escape-run stream encoder: reserved byte codes, run limits
// and the types shared between the run coder, the output queue and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package esr_pkg;

  // Reserved byte values; the low one also serves as the escape marker.
  localparam logic [7:0] EscLow  = 8'hD8;
  localparam logic [7:0] EscHigh = 8'hD9;

  // A run holds at most this many reserved bytes.
  localparam logic [2:0] RunMax = 3'd5;

  // Output queue geometry: room for the three results of one item plus one.
  localparam int QueueDepth = 4;
  localparam int PtrWidth   = 2;
  localparam int CountWidth = 3;

  // Largest number of results that one input item can cause.
  localparam int MaxResults = 3;

  // One coded output byte and its end-of-frame mark.
  typedef struct packed {
    logic [7:0] coded_byte;
    logic       frame_last;
  } esr_entry_t;

  // Results caused by one accepted item, lowest index first.
  typedef struct packed {
    logic [1:0]                  count;
    esr_entry_t [MaxResults-1:0] entry;
  } esr_results_t;

endpackage

`default_nettype wire

// ----- src/esr_coder.sv -----
// Run coder: holds the pending run of reserved bytes and turns each accepted
// item into zero to three coded bytes. Depends on esr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esr_coder (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  frame_end,
  output esr_pkg::esr_results_t      results
);

  logic [2:0] run_length;
  logic [2:0] run_length_next;
  logic [4:0] run_pattern;
  logic [4:0] run_pattern_next;

  logic       is_reserved;
  logic [2:0] grown_length;
  logic [4:0] grown_pattern;
  logic       flush;
  logic [2:0] code_length;
  logic [4:0] code_pattern;
  logic [7:0] code_byte;

  // Extend the pending run with a reserved byte.
  always_comb begin
    is_reserved   = (data_byte == esr_pkg::EscLow) || (data_byte == esr_pkg::EscHigh);
    grown_length  = run_length + 3'd1;
    grown_pattern = run_pattern;
    if (data_byte == esr_pkg::EscHigh) begin
      grown_pattern = run_pattern | (5'd1 << run_length);
    end
  end

  // A run goes out when it fills, ahead of an ordinary byte, or at frame end.
  always_comb begin
    if (is_reserved) begin
      flush = (grown_length == esr_pkg::RunMax) || frame_end;
      code_length  = grown_length;
      code_pattern = grown_pattern;
    end else begin
      flush = (run_length != 3'd0);
      code_length  = run_length;
      code_pattern = run_pattern;
    end
    code_byte = {code_length, code_pattern};
  end

  // Lay out the results and mark the final one of a frame.
  always_comb begin
    results = '0;
    if (flush) begin
      results.entry[0].coded_byte = esr_pkg::EscLow;
      results.entry[1].coded_byte = code_byte;
      if (is_reserved) begin
        results.count = 2'd2;
        results.entry[1].frame_last = frame_end;
      end else begin
        results.count = 2'd3;
        results.entry[2].coded_byte = data_byte;
        results.entry[2].frame_last = frame_end;
      end
    end else if (!is_reserved) begin
      results.count = 2'd1;
      results.entry[0].coded_byte = data_byte;
      results.entry[0].frame_last = frame_end;
    end
  end

  // The run is cleared whenever it is emitted or an ordinary byte arrives.
  always_comb begin
    run_length_next  = run_length;
    run_pattern_next = run_pattern;
    if (accept) begin
      if (flush || !is_reserved) begin
        run_length_next  = 3'd0;
        run_pattern_next = 5'd0;
      end else begin
        run_length_next  = grown_length;
        run_pattern_next = grown_pattern;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length  <= 3'd0;
      run_pattern <= 5'd0;
    end else begin
      run_length  <= run_length_next;
      run_pattern <= run_pattern_next;
    end
  end

`ifndef SYNTHESIS
  // A pending run never reaches the full length between items.
  a_run_short: assert property (@(posedge clk) disable iff (rst)
    run_length < esr_pkg::RunMax)
    else $error("pending run reached full length");

  // The last byte of a frame always produces output.
  a_end_out: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |-> results.count != 2'd0)
    else $error("frame end produced no output");

  // An ordinary byte leaves no run pending.
  a_plain_clears: assert property (@(posedge clk) disable iff (rst)
    accept && !is_reserved |=> run_length == 3'd0 && run_pattern == 5'd0)
    else $error("run left pending after ordinary byte");
`endif

endmodule

`default_nettype wire

// ----- src/esr_out_queue.sv -----
// Output queue: takes up to three coded bytes at once and hands them out one
// per cycle while out_ready is high, and decides when the next item may enter. Depends on esr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esr_out_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire esr_pkg::esr_results_t results,
  output logic                       room,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output esr_pkg::esr_entry_t        out_entry
);

  esr_pkg::esr_entry_t [esr_pkg::QueueDepth-1:0] slots;

  logic [esr_pkg::PtrWidth-1:0]   wr_ptr;
  logic [esr_pkg::PtrWidth-1:0]   rd_ptr;
  logic [esr_pkg::CountWidth-1:0] count;
  logic [esr_pkg::CountWidth-1:0] count_next;
  logic [1:0]                     push_n;
  logic                           pop;

  // An item may enter only while all of its results are sure to fit.
  assign room      = (count <= esr_pkg::CountWidth'(1));
  assign out_valid = (count != '0);
  assign out_entry = slots[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign push_n    = push ? results.count : 2'd0;

  always_comb begin
    count_next = count + esr_pkg::CountWidth'(push_n) - esr_pkg::CountWidth'(pop);
  end

  // Write the new results into consecutive slots.
  always_ff @(posedge clk) begin
    for (int i = 0; i < esr_pkg::MaxResults; i++) begin
      if (2'(i) < push_n) begin
        slots[wr_ptr + esr_pkg::PtrWidth'(i)] <= results.entry[i];
      end
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + esr_pkg::PtrWidth'(push_n);
      rd_ptr <= rd_ptr + esr_pkg::PtrWidth'(pop);
      count  <= count_next;
    end
  end

`ifndef SYNTHESIS
  // The fill level never exceeds the number of slots.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= esr_pkg::CountWidth'(esr_pkg::QueueDepth))
    else $error("output queue overflow");

  // Results are only written while there is room for a whole item.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> count <= esr_pkg::CountWidth'(1))
    else $error("results written without room");

  // A byte that waits for the sink stays offered and unchanged.
  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_entry))
    else $error("waiting output byte changed");
`endif

endmodule

`default_nettype wire

// ----- src/escape_run_stream_encoder.sv -----
// Escape-run stream encoder, top level: run coder feeding a four-slot output queue.
// Coded bytes enter the queue slots on acceptance. Throughput: one item per cycle while
// each item yields at most one byte and the sink is ready; an item that emits a run
// yields two or three bytes, which leave the queue one per cycle while the sink is ready.
// Input is taken while at most one byte is queued, so the sink's pace sets the rate.
// Reset (rst, synchronous) clears the pending run and empties the output queue.
`timescale 1ns / 1ps
`default_nettype none

module escape_run_stream_encoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // frame_end
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] coded_byte
  output logic            m_tlast    // frame_last
);

  esr_pkg::esr_results_t results;
  esr_pkg::esr_entry_t   out_entry;
  logic                  accept;
  logic                  room;

  // An item is taken whenever the queue has room for all of its results.
  assign s_tready = room;
  assign accept   = s_tvalid && room;

  esr_coder u_coder (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .frame_end (s_tlast),
    .results   (results)
  );

  esr_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .results   (results),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_entry (out_entry)
  );

  assign m_tdata = out_entry.coded_byte;
  assign m_tlast = out_entry.frame_last;

endmodule

`default_nettype wire
